>>> hdl/mtba_pkg.sv
// Shared types, codes and the bits-per-pixel table for the mipmap texel
// byte address unit. No dependencies.
package mtba_pkg;

  localparam int TEX_DIM_W  = 15;
  localparam int LEVEL_W    = 4;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int FMT_W      = 5;
  localparam int BPP_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = 32;
  localparam int OFF_W      = 33;
  localparam int FMT_COUNT  = 18;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 3'd0,
    STS_COORD      = 3'd1,
    STS_LEVEL      = 3'd2,
    STS_NON_ORIGIN = 3'd3,
    STS_FORMAT     = 3'd4,
    STS_NO_BASE    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDR  = 3'd0,
    REG_WIDTH      = 3'd1,
    REG_HEIGHT     = 3'd2,
    REG_FORMAT     = 3'd3,
    REG_COMPRESSED = 3'd4,
    REG_SWIZZLED   = 3'd5,
    REG_LAST_LEVEL = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOP,
    S_MULY,
    S_ADD,
    S_SCALE,
    S_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;      // capture input word, run checks
    logic iter;      // one level of the size accumulation
    logic muly;      // level width times row
    logic add;       // texel offset
    logic scale;     // offset times bpp, to bytes
    logic out_load;  // fill the output register
  } ctl_cmd_t;

  typedef struct packed {
    logic err;
    logic loop_done;
  } ctl_sts_t;

  // Bits per pixel for each format; 0 marks an unsupported one.
  function automatic logic [BPP_W-1:0] bpp_lookup(input logic [FMT_W-1:0] fmt);
    logic [BPP_W-1:0] bpp;
    case (fmt)
      5'd0, 5'd1, 5'd2, 5'd15, 5'd16, 5'd17: bpp = 6'd8;
      5'd3, 5'd6, 5'd8, 5'd9:                bpp = 6'd16;
      5'd10, 5'd11:                          bpp = 6'd32;
      5'd14:                                 bpp = 6'd4;
      default:                               bpp = 6'd0;
    endcase
    return bpp;
  endfunction

endpackage

>>> hdl/mtba_ctrl.sv
// Sequencer for the mipmap texel byte address unit: walks one word through
// checks, level accumulation, scaling and output. Uses mtba_pkg.
module mtba_ctrl
  import mtba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_LOOP;
      S_LOOP: begin
        if (sts.err)            state_nxt = S_EMIT;
        else if (sts.loop_done) state_nxt = S_MULY;
      end
      S_MULY:  state_nxt = S_ADD;
      S_ADD:   state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_EMIT;
      S_EMIT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_LOOP:  cmd.iter     = !sts.err && !sts.loop_done;
      S_MULY:  cmd.muly     = 1'b1;
      S_ADD:   cmd.add      = 1'b1;
      S_SCALE: cmd.scale    = 1'b1;
      S_EMIT:  cmd.out_load = slot_free;
      default: cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE)
    else $error("input word taken outside idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result not presented after output load");

endmodule

>>> hdl/mtba_dp.sv
// Datapath for the mipmap texel byte address unit: configuration registers,
// checks, level size accumulator, scaling and output register. Uses mtba_pkg.
module mtba_dp
  import mtba_pkg::*;
#(
  parameter int MIP_LEVELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [TEX_DIM_W-1:0]  texel_x,
  input  logic [TEX_DIM_W-1:0]  texel_y,
  input  logic [LEVEL_W-1:0]    mip_level,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts,
  output logic [ADDR_W-1:0]     byte_address,
  output logic [STATUS_W-1:0]   status
);

  localparam int LVL_W = (MIP_LEVELS > 1) ? $clog2(MIP_LEVELS) : 1;

  // configuration
  logic [ADDR_W-1:0]    base_r;
  logic [TEX_DIM_W-1:0] width0_r, height0_r;
  logic [FMT_W-1:0]     fmt_r;
  logic                 compressed_r, swizzled_r;
  logic [LEVEL_W-1:0]   last_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= '0;
      width0_r     <= TEX_DIM_W'(1);
      height0_r    <= TEX_DIM_W'(1);
      fmt_r        <= '0;
      compressed_r <= 1'b0;
      swizzled_r   <= 1'b0;
      last_level_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BASE_ADDR:  base_r       <= cfg_wdata[ADDR_W-1:0];
        REG_WIDTH:      width0_r     <= cfg_wdata[TEX_DIM_W-1:0];
        REG_HEIGHT:     height0_r    <= cfg_wdata[TEX_DIM_W-1:0];
        REG_FORMAT:     fmt_r        <= cfg_wdata[FMT_W-1:0];
        REG_COMPRESSED: compressed_r <= cfg_wdata[0];
        REG_SWIZZLED:   swizzled_r   <= cfg_wdata[0];
        REG_LAST_LEVEL: last_level_r <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // checks, in priority order
  logic             origin;
  logic [BPP_W-1:0] bpp;
  status_t          chk;

  assign origin = (texel_x == '0) && (texel_y == '0);
  assign bpp    = bpp_lookup(fmt_r);

  always_comb begin
    if (base_r == '0)
      chk = STS_NO_BASE;
    else if (texel_x >= width0_r || texel_y >= height0_r)
      chk = STS_COORD;
    else if (mip_level > last_level_r ||
             {1'b0, mip_level} >= (LEVEL_W+1)'(MIP_LEVELS))
      chk = STS_LEVEL;
    else if ((compressed_r || swizzled_r) && !origin)
      chk = STS_NON_ORIGIN;
    else if (fmt_r >= FMT_W'(FMT_COUNT) || bpp == '0)
      chk = STS_FORMAT;
    else
      chk = STS_OK;
  end

  // working registers
  status_t              status_r;
  logic [TEX_DIM_W-1:0] x_r, y_r, w_r, h_r, min_dim;
  logic [TEX_DIM_W-1:0] w_half, h_half;
  logic [LVL_W-1:0]     cnt_r;
  logic [BPP_W-1:0]     bpp_r;
  logic [SUM_W-1:0]     sum_r;
  logic [2*TEX_DIM_W-1:0] prod_r;
  logic [OFF_W-1:0]     off_r;
  logic [ADDR_W-1:0]    scaled_r;
  logic [ADDR_W-1:0]    out_addr_r;
  logic [STATUS_W-1:0]  out_status_r;

  assign min_dim = compressed_r ? TEX_DIM_W'(4) : TEX_DIM_W'(1);
  assign w_half  = w_r >> 1;
  assign h_half  = h_r >> 1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= chk;
      x_r      <= texel_x;
      y_r      <= texel_y;
      w_r      <= width0_r;
      h_r      <= height0_r;
      cnt_r    <= mip_level[LVL_W-1:0];
      bpp_r    <= bpp;
      sum_r    <= '0;
    end
    if (cmd.iter) begin
      sum_r <= sum_r + SUM_W'(w_r * h_r);
      w_r   <= (w_half >= min_dim) ? w_half : min_dim;
      h_r   <= (h_half >= min_dim) ? h_half : min_dim;
      cnt_r <= cnt_r - LVL_W'(1);
    end
    if (cmd.muly)
      prod_r <= w_r * y_r;
    if (cmd.add)
      off_r <= OFF_W'(sum_r) + OFF_W'(prod_r) + OFF_W'(x_r);
    if (cmd.scale)
      scaled_r <= ADDR_W'(((OFF_W+BPP_W)'(off_r) * (OFF_W+BPP_W)'(bpp_r)) >> 3);
    if (cmd.out_load) begin
      out_addr_r   <= (status_r == STS_OK) ? scaled_r + base_r : '0;
      out_status_r <= status_r;
    end
  end

  assign sts.err       = (status_r != STS_OK);
  assign sts.loop_done = (cnt_r == '0);
  assign byte_address  = out_addr_r;
  assign status        = out_status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_status_r == STS_OK || out_addr_r == '0))
    else $error("nonzero address with error status");

  a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iter |-> cnt_r != '0)
    else $error("level step with no levels left");

  a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> sum_r == '0)
    else $error("accumulator not cleared on load");

endmodule

>>> hdl/mipmap_texel_byte_address.sv
// Mipmap texel byte address unit, top level: stream ports around the
// sequencer and datapath. Uses mtba_pkg, mtba_ctrl and mtba_dp.
// Each word goes through the level walk, row multiply, offset add and bpp
// scaling (straight to output on error); a new word is taken only once its
// result is loaded. The single multiply-accumulate steps one level per cycle.
// Reset (rst_n low, synchronous): config/state to defaults, no result pending.
module mipmap_texel_byte_address
  import mtba_pkg::*;
#(
  parameter int MIP_LEVELS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,   // texel_x[14:0], texel_y[29:15],
                                            // mip_level[33:30], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata   // byte_address[31:0], status[34:32],
                                            // zero pad
);

  ctl_cmd_t              cmd;
  ctl_sts_t              sts;
  logic [ADDR_W-1:0]     byte_address;
  logic [STATUS_W-1:0]   status;

  mtba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mtba_dp #(
    .MIP_LEVELS (MIP_LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .texel_x      (in_tdata[14:0]),
    .texel_y      (in_tdata[29:15]),
    .mip_level    (in_tdata[33:30]),
    .cmd          (cmd),
    .sts          (sts),
    .byte_address (byte_address),
    .status       (status)
  );

  assign out_tdata = {5'd0, status, byte_address};

endmodule
